@@ sv/adll_pkg.sv @@
// ----------------------------------------------------------------------------
// Array doubly linked list package
// Shared widths, codes and the sequencer state type.
// ----------------------------------------------------------------------------
package adll_pkg;

  localparam int SLOTS       = 64;
  localparam int SLOT_W      = 6;
  localparam int FREE_W      = 7;
  localparam int VALUE_W     = 32;
  localparam int MAX_RESULTS = 63;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 40;

  localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ERASE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_ERA_RD,
    S_TRV_HEAD,
    S_TRV_WALK,
    S_EMIT
  } state_t;

endpackage

@@ sv/array_doubly_linked_list.sv @@
// ----------------------------------------------------------------------------
// Array doubly linked list
// Linked list held in value, previous-link and next-link memories.
// ----------------------------------------------------------------------------
// One request is worked at a time. Insert reads the next link, writes the
// node and links its neighbours; erase reads both links and relinks them;
// a bad or full request goes straight to its result. A traverse reads the
// head link, gives an empty status for an empty list, else emits one node
// per cycle while results are taken, each step waiting on the next-link
// read. A result not taken holds the block until it is. Every request ends
// in a result register, so a new request is taken while the last waits.
module array_doubly_linked_list (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // position [5:0], value [37:6], zero [39:38]
  input  logic [adll_pkg::IN_DATA_W-1:0]    s_tdata,
  // command [1:0]
  input  logic [adll_pkg::CMD_W-1:0]        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // item_value [31:0], slot [37:32], zero [39:38]
  output logic [adll_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status [1:0]
  output logic [adll_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast
);

  localparam int SW = adll_pkg::SLOT_W;
  localparam int VW = adll_pkg::VALUE_W;

  adll_pkg::state_t state, state_next;

  logic [adll_pkg::FREE_W-1:0] free_slot, free_slot_next;
  logic                        head_valid, head_valid_next;
  logic [adll_pkg::CMD_W-1:0]  cmd_q;
  logic [SW-1:0]               pos_q, pos_q_next;
  logic [VW-1:0]               val_q, val_q_next;
  logic [SW-1:0]               link_q, link_q_next;
  logic [SW-1:0]               cur, cur_next;
  logic [SW-1:0]               count, count_next;
  logic [SW-1:0]               res_slot, res_slot_next;
  logic [adll_pkg::STATUS_W-1:0] res_status, res_status_next;

  logic [VW-1:0]                 out_value, out_value_next;
  logic [SW-1:0]                 out_slot, out_slot_next;
  logic [adll_pkg::STATUS_W-1:0] out_status, out_status_next;
  logic                          out_last, out_last_next;
  logic                          out_valid;
  logic                          out_load, out_free;

  logic [VW-1:0] value_mem [adll_pkg::SLOTS];
  logic [SW-1:0] prev_mem  [adll_pkg::SLOTS];
  logic [SW-1:0] next_mem  [adll_pkg::SLOTS];

  logic          vs_we, pl_we, nl_we;
  logic [SW-1:0] vs_waddr, pl_waddr, nl_waddr;
  logic [VW-1:0] vs_wdata;
  logic [SW-1:0] pl_wdata, nl_wdata;
  logic          vs_re, pl_re, nl_re;
  logic [SW-1:0] vs_raddr, pl_raddr, nl_raddr;
  logic [VW-1:0] vs_rdata;
  logic [SW-1:0] pl_rdata, nl_rdata;
  logic          nl_rd_zero;
  logic [SW-1:0] nl_eff;

  logic          accept;
  logic [SW-1:0] in_pos;
  logic [SW-1:0] new_slot;
  logic          walk_last;

  assign in_pos   = s_tdata[SW-1:0];
  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == adll_pkg::S_IDLE);
  assign out_free = !out_valid || m_tready;
  assign new_slot = free_slot[SW-1:0];
  // The head link reads as zero until it is first written.
  assign nl_eff   = nl_rd_zero ? '0 : nl_rdata;
  assign walk_last = (nl_eff == '0) || (count == SW'(adll_pkg::MAX_RESULTS - 1));

  always_ff @(posedge clk) begin
    if (vs_we) begin
      value_mem[vs_waddr] <= vs_wdata;
    end
    if (vs_re) begin
      vs_rdata <= value_mem[vs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pl_we) begin
      prev_mem[pl_waddr] <= pl_wdata;
    end
    if (pl_re) begin
      pl_rdata <= prev_mem[pl_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nl_we) begin
      next_mem[nl_waddr] <= nl_wdata;
    end
    if (nl_re) begin
      nl_rdata   <= next_mem[nl_raddr];
      nl_rd_zero <= (nl_raddr == '0) && !head_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= adll_pkg::S_IDLE;
      free_slot  <= adll_pkg::FREE_W'(1);
      head_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      free_slot  <= free_slot_next;
      head_valid <= head_valid_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= s_tuser;
    end
    pos_q      <= pos_q_next;
    val_q      <= val_q_next;
    link_q     <= link_q_next;
    cur        <= cur_next;
    count      <= count_next;
    res_slot   <= res_slot_next;
    res_status <= res_status_next;
    out_value  <= out_value_next;
    out_slot   <= out_slot_next;
    out_status <= out_status_next;
    out_last   <= out_last_next;
  end

  always_comb begin
    state_next      = state;
    free_slot_next  = free_slot;
    head_valid_next = head_valid;
    pos_q_next      = pos_q;
    val_q_next      = val_q;
    link_q_next     = link_q;
    cur_next        = cur;
    count_next      = count;
    res_slot_next   = res_slot;
    res_status_next = res_status;
    out_load        = 1'b0;
    out_value_next  = out_value;
    out_slot_next   = out_slot;
    out_status_next = out_status;
    out_last_next   = out_last;
    vs_we = 1'b0; vs_waddr = new_slot; vs_wdata = val_q;
    pl_we = 1'b0; pl_waddr = new_slot; pl_wdata = pos_q;
    nl_we = 1'b0; nl_waddr = new_slot; nl_wdata = nl_eff;
    vs_re = 1'b0; vs_raddr = nl_eff;
    pl_re = 1'b0; pl_raddr = in_pos;
    nl_re = 1'b0; nl_raddr = in_pos;

    unique case (state)
      adll_pkg::S_IDLE: begin
        if (s_tvalid) begin
          pos_q_next = in_pos;
          val_q_next = s_tdata[SW +: VW];
          case (s_tuser)
            adll_pkg::CMD_INSERT: begin
              if (free_slot == adll_pkg::FREE_W'(adll_pkg::SLOTS)) begin
                res_slot_next   = '0;
                res_status_next = adll_pkg::ST_FULL;
                state_next      = adll_pkg::S_EMIT;
              end else if ({1'b0, in_pos} >= free_slot) begin
                res_slot_next   = in_pos;
                res_status_next = adll_pkg::ST_INVALID;
                state_next      = adll_pkg::S_EMIT;
              end else begin
                nl_re      = 1'b1;
                state_next = adll_pkg::S_INS_RD;
              end
            end
            adll_pkg::CMD_ERASE: begin
              if (in_pos == '0 || {1'b0, in_pos} >= free_slot) begin
                res_slot_next   = in_pos;
                res_status_next = adll_pkg::ST_INVALID;
                state_next      = adll_pkg::S_EMIT;
              end else begin
                nl_re      = 1'b1;
                pl_re      = 1'b1;
                state_next = adll_pkg::S_ERA_RD;
              end
            end
            adll_pkg::CMD_TRAVERSE: begin
              nl_re      = 1'b1;
              nl_raddr   = '0;
              state_next = adll_pkg::S_TRV_HEAD;
            end
            default: begin
              res_slot_next   = '0;
              res_status_next = adll_pkg::ST_INVALID;
              state_next      = adll_pkg::S_EMIT;
            end
          endcase
        end
      end
      adll_pkg::S_INS_RD: begin
        link_q_next = nl_eff;
        vs_we       = 1'b1;
        pl_we       = 1'b1;
        nl_we       = 1'b1;
        state_next  = adll_pkg::S_INS_WR;
      end
      adll_pkg::S_INS_WR: begin
        nl_we    = 1'b1;
        nl_waddr = pos_q;
        nl_wdata = new_slot;
        pl_we    = (link_q != '0);
        pl_waddr = link_q;
        pl_wdata = new_slot;
        if (pos_q == '0) begin
          head_valid_next = 1'b1;
        end
        free_slot_next  = free_slot + adll_pkg::FREE_W'(1);
        res_slot_next   = new_slot;
        res_status_next = adll_pkg::ST_OK;
        state_next      = adll_pkg::S_EMIT;
      end
      adll_pkg::S_ERA_RD: begin
        nl_we    = 1'b1;
        nl_waddr = pl_rdata;
        nl_wdata = nl_eff;
        pl_we    = (nl_eff != '0);
        pl_waddr = nl_eff;
        pl_wdata = pl_rdata;
        if (pl_rdata == '0) begin
          head_valid_next = 1'b1;
        end
        res_slot_next   = pos_q;
        res_status_next = adll_pkg::ST_OK;
        state_next      = adll_pkg::S_EMIT;
      end
      adll_pkg::S_TRV_HEAD: begin
        if (nl_eff == '0) begin
          res_slot_next   = '0;
          res_status_next = adll_pkg::ST_EMPTY;
          state_next      = adll_pkg::S_EMIT;
        end else begin
          vs_re      = 1'b1;
          nl_re      = 1'b1;
          nl_raddr   = nl_eff;
          cur_next   = nl_eff;
          count_next = '0;
          state_next = adll_pkg::S_TRV_WALK;
        end
      end
      adll_pkg::S_TRV_WALK: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_value_next  = vs_rdata;
          out_slot_next   = cur;
          out_status_next = adll_pkg::ST_OK;
          out_last_next   = walk_last;
          if (walk_last) begin
            state_next = adll_pkg::S_IDLE;
          end else begin
            vs_re      = 1'b1;
            nl_re      = 1'b1;
            nl_raddr   = nl_eff;
            cur_next   = nl_eff;
            count_next = count + SW'(1);
          end
        end
      end
      adll_pkg::S_EMIT: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_value_next  = '0;
          out_slot_next   = res_slot;
          out_status_next = res_status;
          out_last_next   = 1'b1;
          state_next      = adll_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = adll_pkg::S_IDLE;
      end
    endcase
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_slot, out_value};
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_slot <= adll_pkg::FREE_W'(adll_pkg::SLOTS) && free_slot != '0)
    else $error("free slot counter out of range");

  a_insert_alloc: assert property (@(posedge clk) disable iff (rst)
    state == adll_pkg::S_INS_WR |=> free_slot == $past(free_slot) + adll_pkg::FREE_W'(1))
    else $error("insert did not allocate exactly one slot");

  a_walk_count: assert property (@(posedge clk) disable iff (rst)
    state == adll_pkg::S_TRV_WALK |-> count < SW'(adll_pkg::MAX_RESULTS))
    else $error("traverse ran past its result limit");

  a_inner_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser == adll_pkg::ST_OK)
    else $error("non-final result with a failing status");

  a_cmd_held: assert property (@(posedge clk) disable iff (rst)
    state == adll_pkg::S_INS_RD |-> cmd_q == adll_pkg::CMD_INSERT)
    else $error("insert sequence entered for another command");

endmodule
